// ----- src/direct_mapped_cache_stats_top_macros.svh -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_STATS_TOP_MACROS_SVH
`define DIRECT_MAPPED_CACHE_STATS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DMCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/dmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: package
// Widths, register indexes, line layout and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dmcs_pkg;

   // Field widths.
   localparam int ADDR_W    = 32;
   localparam int CNT_W     = 32;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 1;

   // Address split limits and reset values.
   localparam int OFFSET_MAX   = 16;
   localparam int INDEX_MAX    = 10;
   localparam int OFFSET_RESET = 5;
   localparam int INDEX_RESET  = 7;

   // The raw set index is at most INDEX_MAX bits wide.
   localparam int RAW_SET_W = INDEX_MAX;

   // Fixed-point shift of the reciprocal used to reduce the set index.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // Width of the set count constant.
   localparam int SET_N_W = 17;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 1'd1;

   // Access kind code.
   localparam logic KIND_WRITE = 1'b1;

   // One line of the tag store.
   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [ADDR_W-1:0] tag;
   } line_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic do_quot;
      logic do_prod;
      logic do_rem;
      logic do_read;
      logic do_update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } status_type;

   // Saturating increment of a running counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

// ----- src/direct_mapped_cache_stats_top.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: top level
// Direct-mapped, write-back, write-allocate tag store with saturating
// access, miss and write-back counters.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole tag store,
// during which req_stall stays high; configuration writes are taken during
// that pass. Each item is split into set and tag as it is accepted, then
// passes through reciprocal multiply, back-multiply, remainder, tag store
// read and update before its result is registered; no new item is accepted
// until that update, as the chain of the set index reduction and the
// single-port registered read of the tag store serve one item at a time. A
// result waits in its output register while the next item is being worked
// on, and the update of that next item waits until the result has been taken.
// Configure offset_bits (index 0) and index_bits (index 1) only while idle.
`default_nettype none

module direct_mapped_cache_stats_top #(
   parameter int SET_COUNT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [dmcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dmcs_pkg::CSR_W-1:0]        csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [dmcs_pkg::ADDR_W-1:0]       req_address,
   input  wire logic                              req_kind,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_hit,
   output logic                                   rsp_writeback,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_access_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_read_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_write_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_read_miss_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_write_miss_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_writeback_count
);
   import dmcs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing and handshakes.
   dmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Tag store, index reduction and counters.
   dmcs_datapath #(
      .SET_COUNT (SET_COUNT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_address          (req_address),
      .req_kind             (req_kind),
      .rsp_hit              (rsp_hit),
      .rsp_writeback        (rsp_writeback),
      .rsp_access_count     (rsp_access_count),
      .rsp_read_count       (rsp_read_count),
      .rsp_write_count      (rsp_write_count),
      .rsp_read_miss_count  (rsp_read_miss_count),
      .rsp_write_miss_count (rsp_write_miss_count),
      .rsp_writeback_count  (rsp_writeback_count)
   );

endmodule

`default_nettype wire

// ----- src/dmcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: controller
// Sequences the clearing pass and the steps of each item, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dmcs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dmcs_pkg::cmd_type          cmd,
   input  wire dmcs_pkg::status_type  status
);
   import dmcs_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_QUOT   = 3'd2;
   localparam logic [2:0] ST_PROD   = 3'd3;
   localparam logic [2:0] ST_REM    = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_UPDATE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       slot_free;

   // The result slot is free when empty or being taken this cycle.
   assign slot_free = !out_valid_ff || !rsp_stall;

   // Commands decoded from the state.
   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.do_quot    = (state_ff == ST_QUOT);
      cmd.do_prod    = (state_ff == ST_PROD);
      cmd.do_rem     = (state_ff == ST_REM);
      cmd.do_read    = (state_ff == ST_READ);
      cmd.do_update  = (state_ff == ST_UPDATE) && slot_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_QUOT;
         end
         ST_QUOT:   state_in = ST_PROD;
         ST_PROD:   state_in = ST_REM;
         ST_REM:    state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Result valid is set by an update and cleared when the item is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.do_update) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ----- src/dmcs_datapath.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: datapath
// Address split, set index reduction, tag store memory, hit check and
// saturating statistics counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "direct_mapped_cache_stats_top_macros.svh"

module dmcs_datapath #(
   parameter int SET_COUNT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dmcs_pkg::cmd_type                 cmd,
   output dmcs_pkg::status_type                   status,
   input  wire logic                              csr_write_enable,
   input  wire logic [dmcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dmcs_pkg::CSR_W-1:0]        csr_write_data,
   input  wire logic [dmcs_pkg::ADDR_W-1:0]       req_address,
   input  wire logic                              req_kind,
   output logic                                   rsp_hit,
   output logic                                   rsp_writeback,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_access_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_read_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_write_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_read_miss_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_write_miss_count,
   output logic [dmcs_pkg::CNT_W-1:0]             rsp_writeback_count
);
   import dmcs_pkg::*;

   localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam logic [SET_N_W-1:0] SET_N = SET_N_W'(SET_COUNT);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SET_COUNT);
   localparam int MUL_A_W = RAW_SET_W + RECIP_W;
   localparam int MUL_B_W = RAW_SET_W + SET_N_W;

   // Configuration registers.
   logic [CSR_W-1:0] offset_ff;
   logic [3:0]       index_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= CSR_W'(OFFSET_RESET);
         index_bits_ff <= 4'(INDEX_RESET);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OFFSET_BITS: offset_ff     <= csr_write_data;
            CSR_INDEX_BITS:  index_bits_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Address split with clamped widths.
   logic [4:0]            ob;
   logic [3:0]            ib;
   logic [ADDR_W-1:0]     shifted;
   logic [RAW_SET_W-1:0]  raw_set;
   logic [ADDR_W-1:0]     tag;

   always_comb begin
      ob      = (offset_ff > 5'(OFFSET_MAX)) ? 5'(OFFSET_MAX) : offset_ff;
      ib      = (index_bits_ff > 4'(INDEX_MAX)) ? 4'(INDEX_MAX) : index_bits_ff;
      shifted = req_address >> ob;
      raw_set = shifted[RAW_SET_W-1:0]
              & ((RAW_SET_W'(1) << ib) - RAW_SET_W'(1));
      tag     = req_address >> (ob + 5'(ib));
   end

   // Item registers captured at acceptance.
   logic [RAW_SET_W-1:0] raw_ff;
   logic [ADDR_W-1:0]    tag_ff;
   logic                 kind_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff  <= raw_set;
         tag_ff  <= tag;
         kind_ff <= req_kind;
      end
   end

   // Set index modulo the set count: reciprocal estimate, back-multiply,
   // then one compare and subtract.
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [RAW_SET_W-1:0] quot_ff;
   logic [RAW_SET_W-1:0] prod_ff;
   logic [RAW_SET_W-1:0] rem0;
   logic [SET_N_W-1:0]   rem0_x;
   logic [SET_N_W-1:0]   rem;
   logic [SET_W-1:0]     set_ff;

   assign mul_a  = MUL_A_W'(raw_ff) * MUL_A_W'(RECIP);
   assign mul_b  = MUL_B_W'(quot_ff) * MUL_B_W'(SET_N);
   assign rem0   = raw_ff - prod_ff;
   assign rem0_x = SET_N_W'(rem0);
   assign rem    = (rem0_x >= SET_N) ? (rem0_x - SET_N) : rem0_x;

   always_ff @(posedge clock) begin
      if (cmd.do_quot) quot_ff <= mul_a[RECIP_SHIFT +: RAW_SET_W];
      if (cmd.do_prod) prod_ff <= mul_b[RAW_SET_W-1:0];
      if (cmd.do_rem)  set_ff  <= rem[SET_W-1:0];
   end

   // Clearing pass counter after reset.
   logic [SET_W-1:0] clear_ff;

   assign status.clear_last = (clear_ff == SET_W'(SET_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (cmd.clear_step && !status.clear_last) begin
         clear_ff <= clear_ff + SET_W'(1);
      end
   end

   // Tag store memory with registered read.
   line_type mem [SET_COUNT];
   line_type rd_ff;
   line_type new_line;
   logic     hit;
   logic     wb;

   assign hit = rd_ff.valid && (rd_ff.tag == tag_ff);
   assign wb  = !hit && rd_ff.valid && rd_ff.dirty;

   always_comb begin
      new_line.valid = 1'b1;
      new_line.dirty = hit ? (rd_ff.dirty || (kind_ff == KIND_WRITE))
                           : (kind_ff == KIND_WRITE);
      new_line.tag   = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clear_ff] <= '0;
      end else if (cmd.do_update) begin
         mem[set_ff] <= new_line;
      end
      if (cmd.do_read) rd_ff <= mem[set_ff];
   end

   // Running counters; they also serve as the result payload, since they
   // change only when a new result is loaded.
   logic [CNT_W-1:0] access_ff, read_ff, write_ff;
   logic [CNT_W-1:0] read_miss_ff, write_miss_ff, wb_count_ff;
   logic             hit_ff, wb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         access_ff     <= '0;
         read_ff       <= '0;
         write_ff      <= '0;
         read_miss_ff  <= '0;
         write_miss_ff <= '0;
         wb_count_ff   <= '0;
      end else if (cmd.do_update) begin
         access_ff <= sat_inc(access_ff);
         if (kind_ff == KIND_WRITE) begin
            write_ff <= sat_inc(write_ff);
            if (!hit) write_miss_ff <= sat_inc(write_miss_ff);
         end else begin
            read_ff <= sat_inc(read_ff);
            if (!hit) read_miss_ff <= sat_inc(read_miss_ff);
         end
         if (wb) wb_count_ff <= sat_inc(wb_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_update) begin
         hit_ff <= hit;
         wb_ff  <= wb;
      end
   end

   assign rsp_hit              = hit_ff;
   assign rsp_writeback        = wb_ff;
   assign rsp_access_count     = access_ff;
   assign rsp_read_count       = read_ff;
   assign rsp_write_count      = write_ff;
   assign rsp_read_miss_count  = read_miss_ff;
   assign rsp_write_miss_count = write_miss_ff;
   assign rsp_writeback_count  = wb_count_ff;

   // Checks on the update and index logic.
   `DMCS_ASSERT_NEXT(a_access_inc, clock, reset, cmd.do_update && (access_ff != '1), access_ff == $past(access_ff) + CNT_W'(1), "access count did not advance on update")
   `DMCS_ASSERT_NOW(a_split_sum, clock, reset, access_ff != '1, {1'b0, access_ff} == ({1'b0, read_ff} + {1'b0, write_ff}), "reads plus writes differ from accesses")
   `DMCS_ASSERT_NOW(a_set_range, clock, reset, cmd.do_read, SET_N_W'(set_ff) < SET_N, "set index beyond the store")
   `DMCS_ASSERT_NOW(a_hit_no_wb, clock, reset, cmd.do_update, !(hit && wb), "hit and write-back together")

endmodule

`default_nettype wire

// ----- dv/tb_direct_mapped_cache_stats_top.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped cache statistics: testbench
// Drives memory accesses through the block under several address splits and
// checks every result, hit flag, write-back flag and all six running counters
// against a tag store mirror kept in the testbench. A short table of hand
// checked accesses comes first, then random accesses built around a small
// pool of hot lines so that hits, dirty evictions and clean refills are
// frequent. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_direct_mapped_cache_stats_top;

   timeunit 1ns;
   timeprecision 1ps;

   import dmcs_pkg::*;

   localparam int  SET_COUNT       = 1024;
   localparam int  WATCHDOG_LIMIT  = 4000;
   localparam int  SETTLE_CYCLES   = 8;
   localparam int  RANDOM_PER_PASS = 160;
   localparam int  GEOMETRY_COUNT  = 8;
   localparam logic KIND_READ      = ~KIND_WRITE;

   // One result item, in port order.
   typedef struct packed {
      logic             hit;
      logic             writeback;
      logic [CNT_W-1:0] access_count;
      logic [CNT_W-1:0] read_count;
      logic [CNT_W-1:0] write_count;
      logic [CNT_W-1:0] read_miss_count;
      logic [CNT_W-1:0] write_miss_count;
      logic [CNT_W-1:0] writeback_count;
   } access_result_type;

   // One access to send; a hand-checked row carries its own expected result.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              kind;
      logic              hand_checked;
      access_result_type golden;
   } access_row_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_OFFSET_BITS;
   logic [CSR_W-1:0]     csr_write_data   = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [ADDR_W-1:0]    req_address      = '0;
   logic                 req_kind         = KIND_READ;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic                 rsp_hit;
   logic                 rsp_writeback;
   logic [CNT_W-1:0]     rsp_access_count;
   logic [CNT_W-1:0]     rsp_read_count;
   logic [CNT_W-1:0]     rsp_write_count;
   logic [CNT_W-1:0]     rsp_read_miss_count;
   logic [CNT_W-1:0]     rsp_write_miss_count;
   logic [CNT_W-1:0]     rsp_writeback_count;

   direct_mapped_cache_stats_top #(
      .SET_COUNT(SET_COUNT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_address         (req_address),
      .req_kind            (req_kind),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hit             (rsp_hit),
      .rsp_writeback       (rsp_writeback),
      .rsp_access_count    (rsp_access_count),
      .rsp_read_count      (rsp_read_count),
      .rsp_write_count     (rsp_write_count),
      .rsp_read_miss_count (rsp_read_miss_count),
      .rsp_write_miss_count(rsp_write_miss_count),
      .rsp_writeback_count (rsp_writeback_count)
   );

   // Mirror of the tag store, its split registers and its counters.
   logic [4:0]        offset_setting = 5'(OFFSET_RESET);
   logic [3:0]        index_setting  = 4'(INDEX_RESET);
   logic [ADDR_W-1:0] tag_mirror   [SET_COUNT];
   bit                valid_mirror [SET_COUNT];
   bit                dirty_mirror [SET_COUNT];
   logic [CNT_W-1:0]  accesses_seen     = '0;
   logic [CNT_W-1:0]  reads_seen        = '0;
   logic [CNT_W-1:0]  writes_seen       = '0;
   logic [CNT_W-1:0]  read_misses_seen  = '0;
   logic [CNT_W-1:0]  write_misses_seen = '0;
   logic [CNT_W-1:0]  evictions_seen    = '0;

   access_row_type    pending_accesses [$];
   access_result_type expected_results [$];
   access_row_type    current_row;
   access_result_type predicted;

   int error_count    = 0;
   int results_seen   = 0;
   int hits_seen      = 0;
   int writebacks_seen = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int stall_mode     = 0;
   int stall_span     = 0;
   int idle_cycles    = 0;

   // Accesses under the reset split, most hand checked: offset 5 bits, index 7 bits.
   access_row_type directed_rows [17] = '{
      '{32'h0000_0000, KIND_READ,  1'b1,
        '{1'b0, 1'b0, 32'd1,  32'd1, 32'd0, 32'd1, 32'd0, 32'd0}},
      '{32'h0000_001F, KIND_WRITE, 1'b1,
        '{1'b1, 1'b0, 32'd2,  32'd1, 32'd1, 32'd1, 32'd0, 32'd0}},
      '{32'h0000_1000, KIND_READ,  1'b1,
        '{1'b0, 1'b1, 32'd3,  32'd2, 32'd1, 32'd2, 32'd0, 32'd1}},
      '{32'hFFFF_FFFF, KIND_WRITE, 1'b1,
        '{1'b0, 1'b0, 32'd4,  32'd2, 32'd2, 32'd2, 32'd1, 32'd1}},
      '{32'hFFFF_FFE0, KIND_READ,  1'b1,
        '{1'b1, 1'b0, 32'd5,  32'd3, 32'd2, 32'd2, 32'd1, 32'd1}},
      '{32'h7FFF_FFE0, KIND_WRITE, 1'b1,
        '{1'b0, 1'b1, 32'd6,  32'd3, 32'd3, 32'd2, 32'd2, 32'd2}},
      '{32'h0000_0000, KIND_READ,  1'b1,
        '{1'b0, 1'b0, 32'd7,  32'd4, 32'd3, 32'd3, 32'd2, 32'd2}},
      '{32'h0000_1000, KIND_WRITE, 1'b1,
        '{1'b0, 1'b0, 32'd8,  32'd4, 32'd4, 32'd3, 32'd3, 32'd2}},
      '{32'h0000_1010, KIND_WRITE, 1'b1,
        '{1'b1, 1'b0, 32'd9,  32'd4, 32'd5, 32'd3, 32'd3, 32'd2}},
      '{32'h0000_0FE0, KIND_READ,  1'b1,
        '{1'b0, 1'b1, 32'd10, 32'd5, 32'd5, 32'd4, 32'd3, 32'd3}},
      '{32'h8000_0000, KIND_READ,  1'b1,
        '{1'b0, 1'b1, 32'd11, 32'd6, 32'd5, 32'd5, 32'd3, 32'd4}},
      '{32'h8000_0000, KIND_READ,  1'b1,
        '{1'b1, 1'b0, 32'd12, 32'd7, 32'd5, 32'd5, 32'd3, 32'd4}},
      '{32'h0000_0020, KIND_READ,  1'b1,
        '{1'b0, 1'b0, 32'd13, 32'd8, 32'd5, 32'd6, 32'd3, 32'd4}},
      '{32'h0000_0020, KIND_WRITE, 1'b1,
        '{1'b1, 1'b0, 32'd14, 32'd8, 32'd6, 32'd6, 32'd3, 32'd4}},
      '{32'h5555_5555, KIND_WRITE, 1'b0, '0},
      '{32'hAAAA_AAAA, KIND_READ,  1'b0, '0},
      '{32'h0000_1020, KIND_READ,  1'b0, '0}
   };

   // Register values for each later pass; out-of-range widths get clamped
   // and the top data bit is dropped by the index register.
   int geometry_offset [GEOMETRY_COUNT] = '{0, 16, 31, 4, 3, 12, -1, 5};
   int geometry_index  [GEOMETRY_COUNT] = '{0, 10, 31, 16, 2, 5, -1, 7};

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Effective split widths after clamping.
   function automatic int effective_offset();
      return (int'(offset_setting) > OFFSET_MAX) ? OFFSET_MAX : int'(offset_setting);
   endfunction

   function automatic int effective_index();
      return (int'(index_setting) > INDEX_MAX) ? INDEX_MAX : int'(index_setting);
   endfunction

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] count);
      return (count == {CNT_W{1'b1}}) ? count : count + 1'b1;
   endfunction

   // Look up one access in the mirror, update it and return the result.
   function automatic access_result_type predict_access(input logic [ADDR_W-1:0] address,
                                                        input logic kind);
      access_result_type outcome;
      int                ob;
      int                ib;
      int                set_index;
      logic [ADDR_W-1:0] line_tag;
      logic              is_write;
      ob        = effective_offset();
      ib        = effective_index();
      set_index = int'((address >> ob) & ((32'd1 << ib) - 32'd1)) % SET_COUNT;
      line_tag  = address >> (ob + ib);
      is_write  = (kind == KIND_WRITE);

      accesses_seen = bump(accesses_seen);
      if (is_write) begin
         writes_seen = bump(writes_seen);
      end else begin
         reads_seen = bump(reads_seen);
      end

      outcome           = '0;
      outcome.hit       = valid_mirror[set_index] && (tag_mirror[set_index] == line_tag);
      if (outcome.hit) begin
         if (is_write) begin
            dirty_mirror[set_index] = 1'b1;
         end
      end else begin
         // A miss refills the line, writing back a dirty victim first.
         if (valid_mirror[set_index] && dirty_mirror[set_index]) begin
            outcome.writeback = 1'b1;
            evictions_seen    = bump(evictions_seen);
         end
         if (is_write) begin
            write_misses_seen = bump(write_misses_seen);
         end else begin
            read_misses_seen = bump(read_misses_seen);
         end
         tag_mirror[set_index]   = line_tag;
         valid_mirror[set_index] = 1'b1;
         dirty_mirror[set_index] = is_write;
      end

      outcome.access_count     = accesses_seen;
      outcome.read_count       = reads_seen;
      outcome.write_count      = writes_seen;
      outcome.read_miss_count  = read_misses_seen;
      outcome.write_miss_count = write_misses_seen;
      outcome.writeback_count  = evictions_seen;
      return outcome;
   endfunction

   // Write one split register and track it in the mirror; only used while idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] which,
                                 input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value;
      if (which == CSR_OFFSET_BITS) begin
         offset_setting = value;
      end else begin
         index_setting = value[3:0];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until every queued item is sent and every result has come back.
   task automatic wait_until_idle();
      while (pending_accesses.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queue random accesses around a pool of hot lines for the current split.
   task automatic queue_random_accesses(input int count);
      logic [ADDR_W-1:0] hot_lines [16];
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] offset_mask;
      access_row_type    row;
      int                ob;
      int                ib;
      int                pick;
      int                slot;
      ob          = effective_offset();
      ib          = effective_index();
      offset_mask = (32'd1 << ob) - 32'd1;
      foreach (hot_lines[i]) begin
         hot_lines[i] = $urandom;
      end
      @(negedge clock);
      for (int n = 0; n < count; n++) begin
         pick    = $urandom_range(0, 99);
         slot    = $urandom_range(0, 15);
         address = hot_lines[slot];
         if (pick < 65) begin
            // Same line, any byte within it: mostly hits.
            address = address ^ ($urandom & offset_mask);
         end else if (pick < 85) begin
            // Same set, new tag: usually forces an eviction; sometimes it becomes hot.
            address = address ^ ($urandom << (ob + ib));
            if ($urandom_range(0, 1) == 0) begin
               hot_lines[slot] = address;
            end
         end else begin
            address = $urandom;
         end
         row              = '0;
         row.address      = address;
         row.kind         = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
         pending_accesses.push_back(row);
      end
   endtask

   // Compare one result item field by field with its expectation.
   task automatic check_result(input access_result_type want,
                               input access_result_type got);
      logic [31:0] want_fields [8];
      logic [31:0] got_fields  [8];
      string       field_names [8];
      field_names = '{"hit", "writeback", "access_count", "read_count", "write_count",
                      "read_miss_count", "write_miss_count", "writeback_count"};
      want_fields = '{32'(want.hit), 32'(want.writeback), want.access_count,
                      want.read_count, want.write_count, want.read_miss_count,
                      want.write_miss_count, want.writeback_count};
      got_fields  = '{32'(got.hit), 32'(got.writeback), got.access_count,
                      got.read_count, got.write_count, got.read_miss_count,
                      got.write_miss_count, got.writeback_count};
      for (int i = 0; i < 8; i++) begin
         if (got_fields[i] !== want_fields[i]) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_names[i], want_fields[i], got_fields[i]);
         end
      end
   endtask

   // Sender: predict each accepted item, then present the next one in bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = predict_access(req_address, req_kind);
            expected_results.push_back(current_row.hand_checked ? current_row.golden
                                                                : predicted);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               current_row = pending_accesses.pop_front();
               req_valid   <= 1'b1;
               req_address <= current_row.address;
               req_kind    <= current_row.kind;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: free-running, lightly random, heavy, or periodic.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(8, 64);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         default: begin
            rsp_stall <= ((stall_span % 5) < 2);
         end
      endcase
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         hits_seen       += int'(rsp_hit);
         writebacks_seen += int'(rsp_writeback);
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result with no access outstanding, expected none, actual hit=%0b",
                     $time, rsp_hit);
         end else begin
            check_result(expected_results.pop_front(),
                         '{rsp_hit, rsp_writeback, rsp_access_count, rsp_read_count,
                           rsp_write_count, rsp_read_miss_count, rsp_write_miss_count,
                           rsp_writeback_count});
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: reset, hand-checked table, then random passes per split.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (directed_rows[i]) begin
         pending_accesses.push_back(directed_rows[i]);
      end
      wait_until_idle();

      for (int g = 0; g < GEOMETRY_COUNT; g++) begin
         write_register(CSR_OFFSET_BITS, (geometry_offset[g] < 0) ?
                        CSR_W'($urandom_range(0, 31)) : CSR_W'(geometry_offset[g]));
         write_register(CSR_INDEX_BITS, (geometry_index[g] < 0) ?
                        CSR_W'($urandom_range(0, 31)) : CSR_W'(geometry_index[g]));
         queue_random_accesses(RANDOM_PER_PASS);
         wait_until_idle();
      end

      $display("Covered %0d accesses over %0d address splits: %0d hits, %0d dirty evictions.",
               results_seen, GEOMETRY_COUNT + 1, hits_seen, writebacks_seen);
      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, expected_results.size());
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/dmcs_pkg.sv
src/dmcs_ctrl.sv
src/dmcs_datapath.sv
src/direct_mapped_cache_stats_top.sv
dv/tb_direct_mapped_cache_stats_top.sv
